### rtl/pcf_pkg.sv
`default_nettype none
// ============================================================================
// pcf_pkg - shared types and constants of the pitch complementary filter
// Fixed-point formats, the arctangent table, the queue word and the divider
// constants used by the front, the queue and the back end.
// ============================================================================
package pcf_pkg;

   // CORDIC coordinates: raw counts * 2^16, with room for the CORDIC gain
   localparam int unsigned CORD_W     = 36;
   // Q.24 angle, covers -pi..pi plus the CORDIC overshoot
   localparam int unsigned ANG_W      = 28;
   localparam int unsigned ATAN_LEN   = 24;
   localparam int unsigned ATAN_IDX_W = 5;

   localparam logic signed [ANG_W-1:0] Q24_HALF_PI = 28'sd26353589;

   // Gyro change: round(|rate*dt| * 4096 / 10^6) = floor((|p|*128 + 15625) / 31250)
   localparam int unsigned DIV_NUM_W = 39;
   localparam int unsigned DIV_LOW_W = 26;                 // bits fed two per step
   localparam int unsigned DIV_STEPS = DIV_LOW_W / 2;
   localparam int unsigned DIV_REM_W = 15;
   localparam logic [DIV_NUM_W-1:0] DIV_BIAS = 39'd15625;
   localparam logic [16:0] DIV_D1 = 17'd31250;
   localparam logic [16:0] DIV_D2 = 17'd62500;
   localparam logic [16:0] DIV_D3 = 17'd93750;

   localparam logic [15:0] ALPHA_RESET = 16'd64225;

   localparam int unsigned QDEPTH  = 2;
   localparam int unsigned QPTR_W  = $clog2(QDEPTH);
   localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

   // pre-rotation applied to the accelerometer vector
   typedef enum logic [1:0] {
      QUAD_NONE = 2'd0,
      QUAD_POS  = 2'd1,
      QUAD_NEG  = 2'd2
   } quad_type;

   // one classified sample, front to back
   typedef struct packed {
      logic               zero_vec;
      quad_type           quad;
      logic signed [16:0] cx0;
      logic signed [16:0] cy0;
      logic signed [32:0] rate_dt;
   } desc_type;

   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

   // atan(2^-i) in Q.24
   function automatic logic signed [ANG_W-1:0] atan_q24(input logic [ATAN_IDX_W-1:0] idx);
      logic signed [ANG_W-1:0] v;
      unique case (idx)
         5'd0:    v = 28'sd13176795;
         5'd1:    v = 28'sd7778716;
         5'd2:    v = 28'sd4110060;
         5'd3:    v = 28'sd2086331;
         5'd4:    v = 28'sd1047214;
         5'd5:    v = 28'sd524117;
         5'd6:    v = 28'sd262123;
         5'd7:    v = 28'sd131069;
         5'd8:    v = 28'sd65536;
         5'd9:    v = 28'sd32768;
         5'd10:   v = 28'sd16384;
         5'd11:   v = 28'sd8192;
         5'd12:   v = 28'sd4096;
         5'd13:   v = 28'sd2048;
         5'd14:   v = 28'sd1024;
         5'd15:   v = 28'sd512;
         5'd16:   v = 28'sd256;
         5'd17:   v = 28'sd128;
         5'd18:   v = 28'sd64;
         5'd19:   v = 28'sd32;
         5'd20:   v = 28'sd16;
         5'd21:   v = 28'sd8;
         5'd22:   v = 28'sd4;
         5'd23:   v = 28'sd2;
         default: v = '0;
      endcase
      return v;
   endfunction

   // raw 17-bit count to CORDIC coordinate (times 2^16)
   function automatic logic signed [CORD_W-1:0] coord_load(input logic signed [16:0] v);
      return {{(CORD_W-33){v[16]}}, v, 16'b0};
   endfunction

endpackage
`default_nettype wire

### rtl/pitch_complementary_filter.sv
`default_nettype none
// ============================================================================
// pitch_complementary_filter - one-axis pitch estimator
// Blends the accelerometer pitch atan2(x, z) with the integrated gyro rate.
// ============================================================================
// Each accepted word carries accelerometer x and z (raw counts, same scale),
// the pitch rate in rad/s as Q3.12 and the microseconds since the previous
// sample. The block finds atan2(x, z) with a vectoring CORDIC, adds
// rate * interval (interval taken in seconds, rounded to Q.24, ties away from
// zero) to the stored pitch, blends the two as
// alpha * gyro_path + (1 - alpha) * accel_pitch with alpha = csr_wr_data/65536,
// and returns the new pitch rounded and saturated to Q3.12. That value is
// also the stored pitch for the next sample. After reset the pitch is zero and
// alpha is 64225/65536. Both accelerometer axes zero give an accelerometer
// pitch of zero. The engine's time on a sample is set by the longer of the
// CORDIC loop, which runs one micro-rotation per cycle on a single shift-add
// stage, and a radix-4 divider that works out the gyro change alongside it.
// A two-entry queue in front of the engine keeps taking words while a result
// waits to be read.
// Write alpha only while the block is idle.
// ============================================================================
module pitch_complementary_filter #(
   parameter int unsigned CORDIC_STEPS = 14
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_z,
   input  logic signed [15:0] req_gyro_y_rate,
   input  logic [15:0]        req_interval_us,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_pitch,
   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data
);

   // gyro-path weight, in 1/65536
   logic [15:0]           blend_alpha_ff, blend_alpha_in;

   logic                  fwd_valid;
   pcf_pkg::desc_type     fwd_desc;
   logic                  q_push;
   logic                  q_pop;
   pcf_pkg::desc_type     q_head;
   pcf_pkg::qstat_type    q_stat;

   assign blend_alpha_in = csr_wr_en ? csr_wr_data : blend_alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_alpha_ff <= pcf_pkg::ALPHA_RESET;
      end else begin
         blend_alpha_ff <= blend_alpha_in;
      end
   end

   // intake: classify the sample and hold it until the queue has room
   pcf_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_accel_x     (req_accel_x),
      .req_accel_z     (req_accel_z),
      .req_gyro_y_rate (req_gyro_y_rate),
      .req_interval_us (req_interval_us),
      .fwd_valid       (fwd_valid),
      .fwd_desc        (fwd_desc),
      .fwd_take        (q_push)
   );

   // advance a classified word whenever the queue is not full
   assign q_push = fwd_valid && !q_stat.full;

   pcf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (fwd_desc),
      .pop       (q_pop),
      .head_desc (q_head),
      .stat      (q_stat)
   );

   // engine: drop one word from the queue at a time and produce its pitch
   pcf_back #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (!q_stat.empty),
      .head_desc   (q_head),
      .head_pop    (q_pop),
      .blend_alpha (blend_alpha_ff),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_pitch   (rsp_pitch)
   );

`ifndef SYNTH
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("queue push while full");

   a_pop_data: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("queue pop while empty");

   a_stat_sane: assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("queue both full and empty");

   a_accept_held: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> fwd_valid)
      else $error("accepted word not held by intake");
`endif

endmodule
`default_nettype wire

### rtl/pcf_front.sv
`default_nettype none
// ============================================================================
// pcf_front - sample intake
// Accepts a sample, pre-rotates the accelerometer vector into the right half
// plane, flags the zero vector and forms rate * interval.
// ============================================================================
module pcf_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic signed [15:0]     req_accel_x,
   input  logic signed [15:0]     req_accel_z,
   input  logic signed [15:0]     req_gyro_y_rate,
   input  logic [15:0]            req_interval_us,
   output logic                   fwd_valid,
   output pcf_pkg::desc_type      fwd_desc,
   input  logic                   fwd_take
);

   logic              valid_ff, valid_in;
   pcf_pkg::desc_type desc_ff, desc_in, desc_new;
   logic              accept;
   logic signed [16:0] dt_s;

   assign req_stall = valid_ff && !fwd_take;
   assign accept    = req_valid && !req_stall;
   assign dt_s      = {1'b0, req_interval_us};

   always_comb begin
      desc_new.zero_vec = (req_accel_x == '0) && (req_accel_z == '0);
      desc_new.rate_dt  = req_gyro_y_rate * dt_s;
      if (req_accel_z[15]) begin
         if (!req_accel_x[15]) begin
            desc_new.quad = pcf_pkg::QUAD_POS;
            desc_new.cx0  = 17'(req_accel_x);
            desc_new.cy0  = -17'(req_accel_z);
         end else begin
            desc_new.quad = pcf_pkg::QUAD_NEG;
            desc_new.cx0  = -17'(req_accel_x);
            desc_new.cy0  = 17'(req_accel_z);
         end
      end else begin
         desc_new.quad = pcf_pkg::QUAD_NONE;
         desc_new.cx0  = 17'(req_accel_z);
         desc_new.cy0  = 17'(req_accel_x);
      end
   end

   always_comb begin
      valid_in = valid_ff;
      desc_in  = desc_ff;
      if (fwd_take) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in = 1'b1;
         desc_in  = desc_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff <= desc_in;
   end

   assign fwd_valid = valid_ff;
   assign fwd_desc  = desc_ff;

endmodule
`default_nettype wire

### rtl/pcf_queue.sv
`default_nettype none
// ============================================================================
// pcf_queue - short sample queue
// Decouples the intake from the filter engine so each side stalls on its own.
// ============================================================================
module pcf_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  pcf_pkg::desc_type     push_desc,
   input  logic                  pop,
   output pcf_pkg::desc_type     head_desc,
   output pcf_pkg::qstat_type    stat
);

   pcf_pkg::desc_type                  mem_ff [pcf_pkg::QDEPTH];
   logic [pcf_pkg::QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [pcf_pkg::QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [pcf_pkg::QCNT_W-1:0]         cnt_ff, cnt_in;

   localparam logic [pcf_pkg::QPTR_W-1:0] PTR_LAST = pcf_pkg::QPTR_W'(pcf_pkg::QDEPTH - 1);
   localparam logic [pcf_pkg::QCNT_W-1:0] CNT_FULL = pcf_pkg::QCNT_W'(pcf_pkg::QDEPTH);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end

   assign head_desc  = mem_ff[rd_ptr_ff];
   assign stat.empty = (cnt_ff == '0);
   assign stat.full  = (cnt_ff == CNT_FULL);

endmodule
`default_nettype wire

### rtl/pcf_back.sv
`default_nettype none
// ============================================================================
// pcf_back - filter engine
// Vectoring CORDIC for atan2, a radix-4 constant divider for the gyro change,
// then the blend, rounding and saturation, and the result register.
// ============================================================================
module pcf_back #(
   parameter int unsigned CORDIC_STEPS = 14
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  pcf_pkg::desc_type     head_desc,
   output logic                  head_pop,
   input  logic [15:0]           blend_alpha,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [15:0]    rsp_pitch
);

   localparam int unsigned CW    = pcf_pkg::CORD_W;
   localparam int unsigned AW    = pcf_pkg::ANG_W;
   localparam int unsigned ITERS = (CORDIC_STEPS < pcf_pkg::ATAN_LEN) ?
                                   CORDIC_STEPS : pcf_pkg::ATAN_LEN;
   localparam int unsigned RUN_CYCLES = (ITERS > pcf_pkg::DIV_STEPS) ?
                                        ITERS : pcf_pkg::DIV_STEPS;
   localparam int unsigned CNT_W  = $clog2(RUN_CYCLES + 1);
   localparam int unsigned DIFF_W = 30;
   localparam int unsigned PROD_W = DIFF_W + 17;
   localparam int unsigned SUM_W  = PROD_W + 1;
   localparam int unsigned QW     = pcf_pkg::DIV_LOW_W;
   localparam int unsigned RW     = pcf_pkg::DIV_REM_W;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RUN_CYCLES - 1);
   localparam logic [CNT_W-1:0] CORD_END = CNT_W'(ITERS);
   localparam logic [CNT_W-1:0] DIV_END  = CNT_W'(pcf_pkg::DIV_STEPS);
   localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(64'd1 << 27);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_RUN  = 5'b00010,
      ST_DIFF = 5'b00100,
      ST_MUL  = 5'b01000,
      ST_FIN  = 5'b10000
   } state_type;

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic signed [CW-1:0]      cx_ff, cx_in, cy_ff, cy_in;
   logic signed [AW-1:0]      ang_ff, ang_in;
   logic                      zero_ff, zero_in;
   logic                      neg_ff, neg_in;
   logic [RW-1:0]             rem_ff, rem_in;
   logic [QW-1:0]             dnd_ff, dnd_in;
   logic [QW-1:0]             quo_ff, quo_in;
   logic signed [DIFF_W-1:0]  diff_ff, diff_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [15:0]        prev_ff, prev_in;
   logic signed [15:0]        pitch_ff, pitch_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   logic [32:0]               mag;
   logic [pcf_pkg::DIV_NUM_W-1:0] num;
   logic signed [CW-1:0]      dx, dy;
   logic signed [AW-1:0]      atan_v;
   logic [16:0]               r4;
   logic signed [DIFF_W-1:0]  gyro;
   logic signed [DIFF_W-1:0]  chg;
   logic signed [16:0]        alpha_s;
   logic signed [SUM_W-1:0]   sum;
   logic signed [19:0]        res;
   logic                      fin_fire;

   assign alpha_s  = {1'b0, blend_alpha};
   assign fin_fire = (state_ff == ST_FIN) && (!rsp_valid_ff || !rsp_stall);
   assign head_pop = (state_ff == ST_IDLE) && head_valid;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      ang_in   = ang_ff;
      zero_in  = zero_ff;
      neg_in   = neg_ff;
      rem_in   = rem_ff;
      dnd_in   = dnd_ff;
      quo_in   = quo_ff;
      diff_in  = diff_ff;
      prod_in  = prod_ff;
      prev_in  = prev_ff;
      pitch_in = pitch_ff;

      mag    = head_desc.rate_dt[32] ? 33'(-head_desc.rate_dt) : 33'(head_desc.rate_dt);
      num    = {1'b0, mag[30:0], 7'b0} + pcf_pkg::DIV_BIAS;
      dx     = cy_ff >>> cnt_ff;
      dy     = cx_ff >>> cnt_ff;
      atan_v = pcf_pkg::atan_q24(pcf_pkg::ATAN_IDX_W'(cnt_ff));
      r4     = {rem_ff, dnd_ff[QW-1 -: 2]};
      chg    = neg_ff ? -DIFF_W'(signed'({1'b0, quo_ff})) : DIFF_W'(signed'({1'b0, quo_ff}));
      gyro   = DIFF_W'(signed'({prev_ff, 12'b0})) + chg;
      sum    = SUM_W'(prod_ff) + (SUM_W'(ang_ff) <<< 16) + ROUND_HALF;
      res    = sum[SUM_W-1:28];

      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               cx_in   = pcf_pkg::coord_load(head_desc.cx0);
               cy_in   = pcf_pkg::coord_load(head_desc.cy0);
               zero_in = head_desc.zero_vec;
               neg_in  = head_desc.rate_dt[32];
               rem_in  = RW'(num[pcf_pkg::DIV_NUM_W-1:QW]);
               dnd_in  = num[QW-1:0];
               quo_in  = '0;
               cnt_in  = '0;
               unique case (head_desc.quad)
                  pcf_pkg::QUAD_POS: ang_in = pcf_pkg::Q24_HALF_PI;
                  pcf_pkg::QUAD_NEG: ang_in = -pcf_pkg::Q24_HALF_PI;
                  default:           ang_in = '0;
               endcase
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            // one CORDIC micro-rotation
            if ((cnt_ff < CORD_END) && !zero_ff) begin
               if (!cy_ff[CW-1]) begin
                  cx_in  = cx_ff + dx;
                  cy_in  = cy_ff - dy;
                  ang_in = ang_ff + atan_v;
               end else begin
                  cx_in  = cx_ff - dx;
                  cy_in  = cy_ff + dy;
                  ang_in = ang_ff - atan_v;
               end
            end
            // two quotient bits of the gyro-change division
            if (cnt_ff < DIV_END) begin
               dnd_in = {dnd_ff[QW-3:0], 2'b00};
               priority if (r4 >= pcf_pkg::DIV_D3) begin
                  rem_in = RW'(r4 - pcf_pkg::DIV_D3);
                  quo_in = {quo_ff[QW-3:0], 2'd3};
               end else if (r4 >= pcf_pkg::DIV_D2) begin
                  rem_in = RW'(r4 - pcf_pkg::DIV_D2);
                  quo_in = {quo_ff[QW-3:0], 2'd2};
               end else if (r4 >= pcf_pkg::DIV_D1) begin
                  rem_in = RW'(r4 - pcf_pkg::DIV_D1);
                  quo_in = {quo_ff[QW-3:0], 2'd1};
               end else begin
                  rem_in = RW'(r4);
                  quo_in = {quo_ff[QW-3:0], 2'd0};
               end
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            diff_in  = gyro - DIFF_W'(ang_ff);
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = diff_ff * alpha_s;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (fin_fire) begin
               priority if (res > 20'sd32767) begin
                  pitch_in = 16'sh7FFF;
               end else if (res < -20'sd32768) begin
                  pitch_in = 16'sh8000;
               end else begin
                  pitch_in = res[15:0];
               end
               prev_in  = pitch_in;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = (rsp_valid_ff && rsp_stall) || fin_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      ang_ff   <= ang_in;
      zero_ff  <= zero_in;
      neg_ff   <= neg_in;
      rem_ff   <= rem_in;
      dnd_ff   <= dnd_in;
      quo_ff   <= quo_in;
      diff_ff  <= diff_in;
      prod_ff  <= prod_in;
      pitch_ff <= pitch_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pitch = pitch_ff;

endmodule
`default_nettype wire

### sim/pitch_complementary_filter_tb.sv
// ----------------------------------------------------------------------------
// pitch_complementary_filter_tb - self-checking bench for the pitch filter
// Drives inertial sample words through the valid/stall request channel. A
// bit-true pitch predictor runs on every accepted word, and each returned
// pitch is compared with the oldest prediction. A directed table comes first,
// then random phases under several blend weights.
// ----------------------------------------------------------------------------
module pitch_complementary_filter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int    CORDIC_STEPS = 14;
   localparam longint HALF_PI_Q24 = 64'sd26353589;
   // atan(2^-i) in Q.24, deep enough for the widest step count
   localparam longint ATAN_Q24 [24] = '{
      13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
      256, 128, 64, 32, 16, 8, 4, 2};
   localparam logic [15:0] ALPHA_AT_RESET = 16'd64225;
   localparam int RANDOM_PHASES   = 8;
   localparam int WORDS_PER_PHASE = 120;
   localparam int SPIN_WORDS      = 40;   // per direction of a saturating spin
   localparam int SETTLE_CYCLES   = 30;

   typedef struct packed {
      logic signed [15:0] ax;
      logic signed [15:0] az;
      logic signed [15:0] rate;
      logic        [15:0] dt;
   } sample_t;

   // one row of the directed table; an alpha write, when flagged, goes first
   typedef struct packed {
      bit                 set_alpha;
      logic        [15:0] alpha;
      logic signed [15:0] ax;
      logic signed [15:0] az;
      logic signed [15:0] rate;
      logic        [15:0] dt;
      bit                 typed;
      logic signed [15:0] want;
   } row_t;

   localparam int DIRECTED_ROWS = 22;
   localparam row_t DIRECTED [DIRECTED_ROWS] = '{
      // all zero straight after reset: nothing to integrate, no tilt
      '{1'b0, 16'd0,          0,      0,      0,     0, 1'b1, 0},
      '{1'b0, 16'd0,      32767,  32767,      0,     0, 1'b0, 0},
      '{1'b0, 16'd0,     -32768,  32767,      0,     0, 1'b0, 0},
      // negative z: pre-rotation by +pi/2 and by -pi/2
      '{1'b0, 16'd0,      32767, -32768,      0,     0, 1'b0, 0},
      '{1'b0, 16'd0,     -32768, -32768,      0,     0, 1'b0, 0},
      '{1'b0, 16'd0,          0, -32768,      0,     0, 1'b0, 0},
      '{1'b0, 16'd0,         -1,     -1,      0,     0, 1'b0, 0},
      '{1'b0, 16'd0,          0,  32767,      0,     0, 1'b0, 0},
      // largest gyro change either way
      '{1'b0, 16'd0,          1,      0,  32767, 65535, 1'b0, 0},
      '{1'b0, 16'd0,          0,     -1, -32768, 65535, 1'b0, 0},
      '{1'b0, 16'd0,        100,    200,      1,     1, 1'b0, 0},
      '{1'b0, 16'd0,         -5,      3,     -1,   123, 1'b0, 0},
      '{1'b0, 16'd0,          7,      7,  12345, 10000, 1'b0, 0},
      // no gyro weight and no tilt vector: pitch is zero whatever the state
      '{1'b1, 16'd0,          0,      0,  32767, 65535, 1'b1, 0},
      '{1'b0, 16'd0,      32767,      0,      0,     0, 1'b0, 0},
      '{1'b0, 16'd0,     -32768,      0,      0,     0, 1'b0, 0},
      '{1'b0, 16'd0,          1, -32768, -32768, 65535, 1'b0, 0},
      // nearly all gyro weight
      '{1'b1, 16'd65535,      0,      0,  32767, 65535, 1'b0, 0},
      '{1'b0, 16'd0,          0,      0,  32767, 65535, 1'b0, 0},
      // zero interval: gyro path is the stored pitch
      '{1'b0, 16'd0,     -32768,  32767, -32768,     0, 1'b0, 0},
      '{1'b1, 16'd32768,  32767,     -1, -32768, 65535, 1'b0, 0},
      '{1'b1, ALPHA_AT_RESET, -32768, 1,  32767,     1, 1'b0, 0}
   };

   logic               clock           = 1'b0;
   logic               reset           = 1'b1;
   logic               req_valid       = 1'b0;
   logic               req_stall;
   logic signed [15:0] req_accel_x     = '0;
   logic signed [15:0] req_accel_z     = '0;
   logic signed [15:0] req_gyro_y_rate = '0;
   logic        [15:0] req_interval_us = '0;
   logic               rsp_valid;
   logic               rsp_stall       = 1'b0;
   logic signed [15:0] rsp_pitch;
   logic               csr_wr_en       = 1'b0;
   logic        [15:0] csr_wr_data     = '0;

   // predictor state: the bench's own copy of the stored pitch and the weight
   logic signed [15:0] stored_pitch = '0;
   logic        [15:0] blend_alpha  = ALPHA_AT_RESET;
   logic signed [15:0] pending_pitch [$];
   int                 errors       = 0;
   bit                 calm         = 1'b0;   // no idling on either side
   int                 stall_left   = 0;
   logic signed [15:0] oldest_pitch;

   pitch_complementary_filter #(.CORDIC_STEPS(CORDIC_STEPS)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_accel_x     (req_accel_x),
      .req_accel_z     (req_accel_z),
      .req_gyro_y_rate (req_gyro_y_rate),
      .req_interval_us (req_interval_us),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pitch       (rsp_pitch),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always #2 clock = ~clock;

   // New filtered pitch for one sample: CORDIC tilt, gyro integration, blend,
   // round to Q3.12 and saturate.
   function automatic logic signed [15:0] filter_step(input logic signed [15:0] prev,
                                                      input logic [15:0] alpha,
                                                      input sample_t s);
      longint ax, az, rate, dt, wgt;
      longint cx, cy, ang, t, dx, dy;
      longint num, mag, chg, gyro, sum, res;
      ax   = s.ax;
      az   = s.az;
      rate = s.rate;
      dt   = s.dt;
      wgt  = alpha;
      ang  = 0;
      if (ax != 0 || az != 0) begin
         cx = az * 65536;
         cy = ax * 65536;
         // fold the left half-plane onto the right so the angle spans -pi..pi
         if (cx < 0) begin
            if (cy >= 0) begin
               t = cx; cx = cy; cy = -t; ang = HALF_PI_Q24;
            end else begin
               t = cx; cx = -cy; cy = t; ang = -HALF_PI_Q24;
            end
         end
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0) begin
               cx += dx; cy -= dy; ang += ATAN_Q24[i];
            end else begin
               cx -= dx; cy += dy; ang -= ATAN_Q24[i];
            end
         end
      end
      // rate * seconds into Q.24, rounded half away from zero
      num = rate * dt * 4096;
      mag = (num < 0) ? -num : num;
      chg = (mag + 500000) / 1000000;
      if (num < 0) chg = -chg;
      gyro = longint'(prev) * 4096 + chg;
      sum  = gyro * wgt + ang * (65536 - wgt);
      res  = (sum + (longint'(1) <<< 27)) >>> 28;
      if (res > 32767)  res = 32767;
      if (res < -32768) res = -32768;
      return res[15:0];
   endfunction

   // idle cycles before the next word on either side
   function automatic int wait_cycles();
      if (calm) return 0;
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 14);
   endfunction

   // a field value biased to the corners of the 16-bit range
   function automatic logic [15:0] corner_value();
      case ($urandom_range(0, 5))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         4:       return 16'h0001;
         default: return 16'($urandom());
      endcase
   endfunction

   // Offer one word, hold it until taken, then predict its pitch. Keep valid
   // high across back-to-back words rather than dropping it for a cycle.
   task automatic send_sample(input sample_t s, input bit typed,
                              input logic signed [15:0] want);
      int                 gap;
      logic signed [15:0] next_pitch;
      gap = wait_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_accel_x     <= s.ax;
      req_accel_z     <= s.az;
      req_gyro_y_rate <= s.rate;
      req_interval_us <= s.dt;
      do @(posedge clock); while (req_stall);
      next_pitch   = filter_step(stored_pitch, blend_alpha, s);
      stored_pitch = next_pitch;
      pending_pitch.push_back(typed ? want : next_pitch);
   endtask

   // drop valid, wait for every outstanding pitch, then let the engine go quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_pitch.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_alpha(input logic [15:0] value);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      blend_alpha = value;
   endtask

   // Result side: take a pitch word whenever not stalling, compare it with the
   // oldest prediction, then draw the stall that precedes the next word.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pitch.size() == 0) begin
            errors++;
            $display("%0t: unexpected pitch word, expected none, got %0d", $time, rsp_pitch);
         end else begin
            oldest_pitch = pending_pitch.pop_front();
            if (rsp_pitch !== oldest_pitch) begin
               errors++;
               $display("%0t: pitch mismatch, expected %0d, got %0d",
                        $time, oldest_pitch, rsp_pitch);
            end
         end
         stall_left = wait_cycles();
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      sample_t     s;
      row_t        r;
      logic [15:0] alpha_pick;
      bit          spin;
      int          kind;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int n = 0; n < DIRECTED_ROWS; n++) begin
         r = DIRECTED[n];
         if (r.set_alpha) set_alpha(r.alpha);
         s = '{ax: r.ax, az: r.az, rate: r.rate, dt: r.dt};
         send_sample(s, r.typed, r.want);
      end

      // random phases, each under its own blend weight
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0, 7:    alpha_pick = 16'd65535;
            1:       alpha_pick = 16'd0;
            2:       alpha_pick = ALPHA_AT_RESET;
            4:       alpha_pick = 16'd32768;
            5:       alpha_pick = 16'd1;
            default: alpha_pick = 16'($urandom());
         endcase
         set_alpha(alpha_pick);
         calm = (p == 2) || ($urandom_range(0, 4) == 0);
         // heavy gyro weight: open with a spin hard one way then the other,
         // driving the pitch into both saturation limits
         spin = (alpha_pick >= 16'd60000);
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
               s = sample_t'({$urandom(), $urandom()});
            end else if (kind < 65) begin
               s.ax   = 16'(int'($urandom_range(0, 16)) - 8);
               s.az   = 16'(int'($urandom_range(0, 16)) - 8);
               s.rate = 16'($urandom());
               s.dt   = 16'($urandom_range(0, 20000));
            end else if (kind < 80) begin
               s.ax   = corner_value();
               s.az   = corner_value();
               s.rate = corner_value();
               s.dt   = corner_value();
            end else begin
               // bench-top IMU at about 100 Hz
               s.ax   = 16'(int'($urandom_range(0, 32768)) - 16384);
               s.az   = 16'(int'($urandom_range(0, 32768)) - 16384);
               s.rate = 16'(int'($urandom_range(0, 4000)) - 2000);
               s.dt   = 16'($urandom_range(9000, 11000));
            end
            if (spin && n < 2 * SPIN_WORDS) begin
               s.rate = (n < SPIN_WORDS) ? 16'sh7FFF : 16'sh8000;
               s.dt   = 16'hFFFF;
            end
            send_sample(s, 1'b0, '0);
         end
      end

      // drain and give the block time to show any stray word
      settle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("PASS pitch_complementary_filter");
      end else begin
         $display("FAIL pitch_complementary_filter");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("FAIL pitch_complementary_filter");
      $finish;
   end

endmodule
